// File: hdl/assert_macros.svh
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Invariant that holds at every edge out of reset.
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

`endif

// File: hdl/dap_pkg.sv
package dap_pkg;

    localparam int unsigned MAX_CHARS_DEF = 15;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned AMOUNT_W  = 47;
    localparam int unsigned INT_ACC_W = 40;
    localparam int unsigned INT_X10_W = 44;
    localparam int unsigned FRAC_W    = 7;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned DAP_W     = 2;

    localparam logic [INT_ACC_W-1:0] INT_LIMIT = 40'd999999999999;
    localparam logic [INT_ACC_W-1:0] INT_SAT   = 40'd1000000000000;

    localparam logic [CHAR_W-1:0] CHAR_TERM  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [DAP_W-1:0] FRAC_DIGITS = 2'd2;
    localparam logic [DAP_W-1:0] DAP_SAT     = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FORMAT  = 2'd1,
        STATUS_NO_INT  = 2'd2,
        STATUS_RANGE   = 2'd3
    } status_t;

endpackage

// File: hdl/decimal_amount_parser.sv
// Parses an ASCII amount string arriving one byte per request, byte 0 ending it, and
// returns one result per string: a status (ok, bad format, no integer part, integer
// part above 999999999999) and the amount in hundredths, zero unless ok. One byte is
// taken every cycle while char_stall is low; a request sits in an input register and the
// next cycle updates the running accumulators (a times-ten shift-add), or on a
// terminator loads the result register, which holds while res_stall is high. A
// terminator waits in the input register only while the result register is full and
// stalled. Strings longer than MAX_CHARS bytes are reported as bad format.
`include "assert_macros.svh"

module decimal_amount_parser #(
    parameter int unsigned MAX_CHARS = dap_pkg::MAX_CHARS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             char_valid,
    output logic                             char_stall,
    input  logic [dap_pkg::CHAR_W-1:0]       char_code,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [dap_pkg::STATUS_W-1:0]     status,
    output logic [dap_pkg::AMOUNT_W-1:0]     amount_cents
);

    localparam int unsigned CNT_W = $clog2(MAX_CHARS + 2);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CHARS);
    localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(MAX_CHARS + 1);

    // input register
    logic                            in_vld_reg;
    logic [dap_pkg::CHAR_W-1:0]      in_char_reg;

    // parse state
    logic [dap_pkg::INT_ACC_W-1:0]   int_reg,   int_next;
    logic [dap_pkg::FRAC_W-1:0]      frac_reg,  frac_next;
    logic [CNT_W-1:0]                cnt_reg,   cnt_next;
    logic                            point_reg, point_next;
    logic [dap_pkg::DAP_W-1:0]       dap_reg,   dap_next;
    logic                            lead_reg,  lead_next;
    logic                            err_reg,   err_next;

    // result register
    logic                            out_vld_reg;
    logic [dap_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [dap_pkg::AMOUNT_W-1:0]    amount_reg, amount_next;

    logic                            is_term;
    logic                            is_digit;
    logic                            in_fire;
    logic                            take_term;
    logic [dap_pkg::DIGIT_W-1:0]     digit;
    logic [dap_pkg::CHAR_W-1:0]      char_off;
    logic [dap_pkg::INT_X10_W-1:0]   int_wide;
    logic [dap_pkg::INT_X10_W-1:0]   int_x10;
    logic [dap_pkg::FRAC_W-1:0]      frac_x10;
    logic [dap_pkg::AMOUNT_W-1:0]    int_amt;
    logic [dap_pkg::AMOUNT_W-1:0]    amount_ok;

    assign is_term  = (in_char_reg == dap_pkg::CHAR_TERM);
    assign is_digit = (in_char_reg >= dap_pkg::CHAR_ZERO) && (in_char_reg <= dap_pkg::CHAR_NINE);
    assign char_off = in_char_reg - dap_pkg::CHAR_ZERO;
    assign digit    = char_off[dap_pkg::DIGIT_W-1:0];

    // a terminator needs room in the result register; other bytes always advance
    assign in_fire    = in_vld_reg && (!is_term || !out_vld_reg || !res_stall);
    assign char_stall = in_vld_reg && !in_fire;
    assign take_term  = in_fire && is_term;

    assign int_wide = {{(dap_pkg::INT_X10_W - dap_pkg::INT_ACC_W){1'b0}}, int_reg};
    assign int_x10  = (int_wide << 3) + (int_wide << 1)
                    + {{(dap_pkg::INT_X10_W - dap_pkg::DIGIT_W){1'b0}}, digit};
    assign frac_x10 = (frac_reg << 3) + (frac_reg << 1)
                    + {{(dap_pkg::FRAC_W - dap_pkg::DIGIT_W){1'b0}}, digit};

    // integer part times 100 as 64 + 32 + 4
    assign int_amt   = {{(dap_pkg::AMOUNT_W - dap_pkg::INT_ACC_W){1'b0}}, int_reg};
    assign amount_ok = (int_amt << 6) + (int_amt << 5) + (int_amt << 2)
                     + {{(dap_pkg::AMOUNT_W - dap_pkg::FRAC_W){1'b0}}, frac_reg};

    always_comb
    begin
        int_next    = int_reg;
        frac_next   = frac_reg;
        cnt_next    = cnt_reg;
        point_next  = point_reg;
        dap_next    = dap_reg;
        lead_next   = lead_reg;
        err_next    = err_reg;
        status_next = status_reg;
        amount_next = amount_reg;

        if (in_fire && is_term)
        begin
            priority if (err_reg || (point_reg && (dap_reg != dap_pkg::FRAC_DIGITS)))
            begin
                status_next = dap_pkg::STATUS_FORMAT;
                amount_next = '0;
            end
            else if ((cnt_reg == '0) || !lead_reg)
            begin
                status_next = dap_pkg::STATUS_NO_INT;
                amount_next = '0;
            end
            else if (int_reg > dap_pkg::INT_LIMIT)
            begin
                status_next = dap_pkg::STATUS_RANGE;
                amount_next = '0;
            end
            else
            begin
                status_next = dap_pkg::STATUS_OK;
                amount_next = amount_ok;
            end
            int_next   = '0;
            frac_next  = '0;
            cnt_next   = '0;
            point_next = 1'b0;
            dap_next   = '0;
            lead_next  = 1'b0;
            err_next   = 1'b0;
        end
        else if (in_fire && !err_reg)
        begin
            if (cnt_reg >= CNT_LIMIT)
            begin
                cnt_next = CNT_SAT;
                err_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
                priority if (is_digit)
                begin
                    if (cnt_reg == '0)
                    begin
                        lead_next = 1'b1;
                    end
                    if (point_reg)
                    begin
                        if (dap_reg < dap_pkg::FRAC_DIGITS)
                        begin
                            frac_next = frac_x10;
                        end
                        if (dap_reg < dap_pkg::DAP_SAT)
                        begin
                            dap_next = dap_reg + 1'b1;
                        end
                    end
                    else if (int_x10 > {{(dap_pkg::INT_X10_W - dap_pkg::INT_ACC_W){1'b0}},
                                        dap_pkg::INT_LIMIT})
                    begin
                        int_next = dap_pkg::INT_SAT;
                    end
                    else
                    begin
                        int_next = int_x10[dap_pkg::INT_ACC_W-1:0];
                    end
                end
                else if (in_char_reg == dap_pkg::CHAR_POINT)
                begin
                    if (point_reg)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        point_next = 1'b1;
                    end
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            int_reg     <= '0;
            frac_reg    <= '0;
            cnt_reg     <= '0;
            point_reg   <= 1'b0;
            dap_reg     <= '0;
            lead_reg    <= 1'b0;
            err_reg     <= 1'b0;
        end
        else
        begin
            if (!char_stall)
            begin
                in_vld_reg <= char_valid;
            end
            // hold a stalled result, load a new one on a terminator
            out_vld_reg <= (in_fire && is_term) || (out_vld_reg && res_stall);
            int_reg     <= int_next;
            frac_reg    <= frac_next;
            cnt_reg     <= cnt_next;
            point_reg   <= point_next;
            dap_reg     <= dap_next;
            lead_reg    <= lead_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall)
        begin
            in_char_reg <= char_code;
        end
        status_reg <= status_next;
        amount_reg <= amount_next;
    end

    assign res_valid    = out_vld_reg;
    assign status       = status_reg;
    assign amount_cents = amount_reg;

    `ASSERT_IMPL(a_err_zero_amount, res_valid && (status != dap_pkg::STATUS_OK), amount_cents == '0)
    `ASSERT_NEXT(a_term_clears, take_term, ({cnt_reg, int_reg} == '0) && !point_reg && !err_reg)
    `ASSERT_NEXT(a_err_freezes, err_reg && !take_term, $stable({int_reg, cnt_reg, frac_reg}))
    `ASSERT_ALWAYS(a_bounds, (cnt_reg <= CNT_SAT) && (int_reg <= dap_pkg::INT_SAT))

endmodule
